/* rtl/mask_value_postprocess_assert.svh */
// Assertion macros shared by the mask value postprocess RTL.
`ifndef MASK_VALUE_POSTPROCESS_ASSERT_SVH
`define MASK_VALUE_POSTPROCESS_ASSERT_SVH
`ifndef SYNTHESIS
`define MVP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mask_value_postprocess: assertion failed");
`define MVP_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mask_value_postprocess: reset assertion failed");
`else
`define MVP_ASSERT(lbl, clk, rst_n, prop)
`define MVP_ASSERT_RST(lbl, clk, prop)
`endif
`endif

/* rtl/mvp_pkg.sv */
package mvp_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int SIG_DEPTH  = 256;
    localparam int SIG_IDX_W  = $clog2(SIG_DEPTH);
    localparam int SAMPLE_W   = 16;
    localparam int MAG_FRAC_W = SAMPLE_W - 1;
    localparam int POS_W      = SAMPLE_W + SIG_IDX_W;
    localparam int GAIN_W     = 16;
    localparam int LEVEL_W    = 13;
    localparam int VAL_W      = FRAC_BITS + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int GAIN_FLOOR = (ONE + 50) / 100;
    localparam int PROD_W     = 2 * (SAMPLE_W + 1);
    localparam int PRODQ_W    = PROD_W - FRAC_BITS;
    localparam int NSUM_W     = LEVEL_W + 4;
    localparam int DEN_W      = LEVEL_W + 1;
    localparam int NUM_W      = DEN_W + FRAC_BITS;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = (FRAC_BITS + DIV_STEP) / DIV_STEP;
    localparam int QUO_W      = DIV_STEP * DIV_STAGES;
    localparam int INTERP_W   = VAL_W + MAG_FRAC_W;
    localparam int TT_W       = 2 * VAL_W;
    localparam int POLY_W     = FRAC_BITS + 2;
    localparam int CUBE_W     = TT_W + POLY_W;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SAMPLE_W:0]   t_ext;
    typedef logic [SAMPLE_W-1:0]        t_mag;
    typedef logic [POS_W-1:0]           t_pos;
    typedef logic [MAG_FRAC_W-1:0]      t_frac;
    typedef logic [GAIN_W-1:0]          t_gain;
    typedef logic [LEVEL_W-1:0]         t_level;
    typedef logic [VAL_W-1:0]           t_val;
    typedef logic [INTERP_W-1:0]        t_interp;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic [PROD_W-1:0]          t_prod_u;
    typedef logic [PRODQ_W-1:0]         t_prodq;
    typedef logic signed [NSUM_W-1:0]   t_nsum;
    typedef logic [DEN_W-1:0]           t_den;
    typedef logic [NUM_W-1:0]           t_num;
    typedef logic [QUO_W-1:0]           t_quo;
    typedef logic [TT_W-1:0]            t_tt;
    typedef logic [POLY_W-1:0]          t_poly;
    typedef logic [CUBE_W-1:0]          t_cube;

    localparam t_val ONE_V = t_val'(ONE);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN       = 3'd0,
        CFG_SIG_ENABLE = 3'd1,
        CFG_SIG_APPLY  = 3'd2,
        CFG_THRESHOLD  = 3'd3,
        CFG_FEATHER    = 3'd4,
        CFG_INVERT     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_gain  gain;
        logic   sig_enable;
        logic   sig_apply;
        t_level threshold;
        t_level feather;
        logic   invert;
    } t_cfg;

    typedef enum logic [1:0] {
        SHAPE_ZERO,
        SHAPE_ONE,
        SHAPE_RAMP
    } t_shape;

    typedef struct packed {
        t_shape shape;
        t_den   rem;
        t_den   den;
        t_quo   low;
        t_quo   quo;
    } t_div;

    typedef t_val t_sig_rom [SIG_DEPTH];

    localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
    localparam logic [63:0] EXP_NEG1_Q30 = 64'd395007542;

    // Restoring division, evaluated only while building the sigmoid table.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_neg_q30(input logic [63:0] x);
        logic [63:0] whole;
        logic [63:0] f;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] z;
        whole = x >> 30;
        f     = x & (Q30_ONE - 64'd1);
        term  = Q30_ONE;
        sum   = Q30_ONE;
        for (int k = 1; k <= 20; k++) begin
            term = udiv64((term * f) >> 30, 64'(k));
            sum  = sum + term;
        end
        z = udiv64((64'd1 << 60) + (sum >> 1), sum);
        for (int w = 0; w < 64; w++) begin
            if (64'(w) < whole && z != 64'd0) begin
                z = (z * EXP_NEG1_Q30 + (Q30_ONE >> 1)) >> 30;
            end
        end
        return z;
    endfunction

    function automatic t_val sig_entry(input int unsigned i);
        logic [63:0] xq;
        logic [63:0] den;
        logic [63:0] num;
        xq  = udiv64(64'(i) << (45 - FRAC_BITS), 64'(SIG_DEPTH));
        den = Q30_ONE + exp_neg_q30(xq);
        num = 64'd1 << (FRAC_BITS + 30);
        return t_val'(udiv64(num + (den >> 1), den));
    endfunction

    function automatic t_sig_rom sig_table(input int unsigned offset);
        t_sig_rom tab;
        for (int i = 0; i < SIG_DEPTH; i++) begin
            tab[i] = sig_entry(32'(i) + offset);
        end
        return tab;
    endfunction

    localparam t_sig_rom SIG_LO   = sig_table(0);
    localparam t_sig_rom SIG_HI   = sig_table(1);
    localparam t_val     SIG_LAST = sig_entry(SIG_DEPTH);

endpackage

/* rtl/mvp_in_if.sv */
interface mvp_in_if;
    logic             valid;
    logic             ready;
    mvp_pkg::t_sample raw_sample;

    modport source(output valid, output raw_sample, input ready);
    modport sink(input valid, input raw_sample, output ready);
endinterface

/* rtl/mvp_out_if.sv */
interface mvp_out_if;
    logic          valid;
    logic          ready;
    mvp_pkg::t_val mask_value;

    modport source(output valid, output mask_value, input ready);
    modport sink(input valid, input mask_value, output ready);
endinterface

/* rtl/mvp_sigmoid.sv */
module mvp_sigmoid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mvp_pkg::t_cfg    i_cfg,
    input  logic             i_vld,
    input  mvp_pkg::t_sample i_sample,
    output logic             o_rdy,
    output logic             o_vld,
    output mvp_pkg::t_ext    o_v,
    input  logic             i_rdy
);
    logic                              en_a;
    logic                              en_b;
    mvp_pkg::t_mag                     raw_u;
    mvp_pkg::t_mag                     mag;
    mvp_pkg::t_pos                     pos;
    logic [mvp_pkg::SIG_IDX_W:0]       idx_full;
    logic [mvp_pkg::SIG_IDX_W-1:0]     idx;
    logic                              at_end;
    mvp_pkg::t_val                     n_lo;
    mvp_pkg::t_val                     n_hi;

    logic             r_vld_a;
    mvp_pkg::t_val    r_lo;
    mvp_pkg::t_val    r_hi;
    mvp_pkg::t_frac   r_frac;
    logic             r_neg;
    mvp_pkg::t_sample r_sample;

    mvp_pkg::t_val    diff;
    mvp_pkg::t_interp interp;
    mvp_pkg::t_val    y;
    mvp_pkg::t_val    sig;
    mvp_pkg::t_ext    n_v;

    logic             r_vld_b;
    mvp_pkg::t_ext    r_v;

    assign en_b  = !r_vld_b || i_rdy;
    assign en_a  = !r_vld_a || en_b;
    assign o_rdy = en_a;
    assign o_vld = r_vld_b;
    assign o_v   = r_v;

    always_comb begin
        raw_u    = i_sample;
        mag      = raw_u[mvp_pkg::SAMPLE_W-1] ? (~raw_u + 1'b1) : raw_u;
        pos      = {mag, {mvp_pkg::SIG_IDX_W{1'b0}}};
        idx_full = pos[mvp_pkg::POS_W-1:mvp_pkg::MAG_FRAC_W];
        idx      = idx_full[mvp_pkg::SIG_IDX_W-1:0];
        at_end   = idx_full[mvp_pkg::SIG_IDX_W];
        n_lo     = at_end ? mvp_pkg::SIG_LAST : mvp_pkg::SIG_LO[idx];
        n_hi     = at_end ? mvp_pkg::SIG_LAST : mvp_pkg::SIG_HI[idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (en_a) begin
            r_vld_a <= i_vld;
        end
        if (en_a) begin
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_frac   <= pos[mvp_pkg::MAG_FRAC_W-1:0];
            r_neg    <= i_sample[mvp_pkg::SAMPLE_W-1];
            r_sample <= i_sample;
        end
    end

    always_comb begin
        diff   = r_hi - r_lo;
        interp = mvp_pkg::t_interp'(diff) * mvp_pkg::t_interp'(r_frac)
               + mvp_pkg::t_interp'(1 << (mvp_pkg::MAG_FRAC_W - 1));
        y      = r_lo + interp[mvp_pkg::INTERP_W-1:mvp_pkg::MAG_FRAC_W];
        sig    = r_neg ? (mvp_pkg::ONE_V - y) : y;
        if (i_cfg.sig_enable && i_cfg.sig_apply) begin
            n_v = $signed({{(mvp_pkg::SAMPLE_W + 1 - mvp_pkg::VAL_W){1'b0}}, sig});
        end else begin
            n_v = {r_sample[mvp_pkg::SAMPLE_W-1], r_sample};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (en_b) begin
            r_vld_b <= r_vld_a;
        end
        if (en_b) begin
            r_v <= n_v;
        end
    end
endmodule

/* rtl/mvp_gain.sv */
module mvp_gain (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mvp_pkg::t_cfg i_cfg,
    input  logic          i_vld,
    input  mvp_pkg::t_ext i_v,
    output logic          o_rdy,
    output logic          o_vld,
    output mvp_pkg::t_div o_dat,
    input  logic          i_rdy
);
    logic en_a;
    logic en_b;
    logic en_c;

    mvp_pkg::t_gain   g;
    mvp_pkg::t_ext    g_s;
    mvp_pkg::t_prod   n_prod;
    logic             r_vld_a;
    mvp_pkg::t_prod   r_prod;

    mvp_pkg::t_prod_u rnd;
    mvp_pkg::t_prodq  q_hi;
    mvp_pkg::t_val    n_val;
    logic             r_vld_b;
    mvp_pkg::t_val    r_val;

    mvp_pkg::t_nsum   nsum;
    mvp_pkg::t_den    twof;
    mvp_pkg::t_num    num;
    mvp_pkg::t_div    n_dat;
    logic             r_vld_c;
    mvp_pkg::t_div    r_dat;

    assign en_c  = !r_vld_c || i_rdy;
    assign en_b  = !r_vld_b || en_c;
    assign en_a  = !r_vld_a || en_b;
    assign o_rdy = en_a;
    assign o_vld = r_vld_c;
    assign o_dat = r_dat;

    always_comb begin
        g      = (i_cfg.gain < mvp_pkg::t_gain'(mvp_pkg::GAIN_FLOOR)) ?
                 mvp_pkg::t_gain'(mvp_pkg::GAIN_FLOOR) : i_cfg.gain;
        g_s    = $signed({1'b0, g});
        n_prod = i_v * g_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (en_a) begin
            r_vld_a <= i_vld;
        end
        if (en_a) begin
            r_prod <= n_prod;
        end
    end

    always_comb begin
        rnd  = $unsigned(r_prod) + mvp_pkg::t_prod_u'(mvp_pkg::ONE / 2);
        q_hi = rnd[mvp_pkg::PROD_W-1:mvp_pkg::FRAC_BITS];
        if (r_prod[mvp_pkg::PROD_W-1] || r_prod == '0) begin
            n_val = '0;
        end else if (q_hi > mvp_pkg::t_prodq'(mvp_pkg::ONE)) begin
            n_val = mvp_pkg::ONE_V;
        end else begin
            n_val = q_hi[mvp_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (en_b) begin
            r_vld_b <= r_vld_a;
        end
        if (en_b) begin
            r_val <= n_val;
        end
    end

    always_comb begin
        twof = {i_cfg.feather, 1'b0};
        nsum = $signed({3'b000, r_val, 1'b0}) - $signed({3'b000, i_cfg.threshold, 1'b0})
             + $signed({4'b0000, i_cfg.feather});
        num  = {nsum[mvp_pkg::DEN_W-1:0], {mvp_pkg::FRAC_BITS{1'b0}}}
             + mvp_pkg::t_num'(i_cfg.feather);
        n_dat.rem = mvp_pkg::t_den'(num >> mvp_pkg::QUO_W);
        n_dat.low = num[mvp_pkg::QUO_W-1:0];
        n_dat.den = twof;
        n_dat.quo = '0;
        if (i_cfg.feather == '0) begin
            n_dat.shape = (r_val >= i_cfg.threshold) ? mvp_pkg::SHAPE_ONE : mvp_pkg::SHAPE_ZERO;
        end else if (nsum <= 0) begin
            n_dat.shape = mvp_pkg::SHAPE_ZERO;
        end else if (nsum >= $signed({3'b000, twof})) begin
            n_dat.shape = mvp_pkg::SHAPE_ONE;
        end else begin
            n_dat.shape = mvp_pkg::SHAPE_RAMP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
        end else if (en_c) begin
            r_vld_c <= r_vld_b;
        end
        if (en_c) begin
            r_dat <= n_dat;
        end
    end
endmodule

/* rtl/mvp_div.sv */
`include "mask_value_postprocess_assert.svh"

module mvp_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  mvp_pkg::t_div i_dat,
    output logic          o_rdy,
    output logic          o_vld,
    output mvp_pkg::t_div o_dat,
    input  logic          i_rdy
);
    logic [mvp_pkg::DIV_STAGES:0]   en;
    logic [mvp_pkg::DIV_STAGES-1:0] src_vld;
    mvp_pkg::t_div                  src [mvp_pkg::DIV_STAGES];
    logic [mvp_pkg::DIV_STAGES-1:0] r_vld;
    mvp_pkg::t_div                  r_dat [mvp_pkg::DIV_STAGES];

    function automatic mvp_pkg::t_div div_step(input mvp_pkg::t_div d);
        mvp_pkg::t_div          o;
        logic [mvp_pkg::DEN_W:0] wide;
        o = d;
        for (int j = 0; j < mvp_pkg::DIV_STEP; j++) begin
            wide  = {o.rem, o.low[mvp_pkg::QUO_W-1]};
            o.low = {o.low[mvp_pkg::QUO_W-2:0], 1'b0};
            if (wide >= {1'b0, o.den}) begin
                o.rem = mvp_pkg::t_den'(wide - {1'b0, o.den});
                o.quo = {o.quo[mvp_pkg::QUO_W-2:0], 1'b1};
            end else begin
                o.rem = wide[mvp_pkg::DEN_W-1:0];
                o.quo = {o.quo[mvp_pkg::QUO_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    assign en[mvp_pkg::DIV_STAGES] = i_rdy;
    assign o_rdy = en[0];
    assign o_vld = r_vld[mvp_pkg::DIV_STAGES-1];
    assign o_dat = r_dat[mvp_pkg::DIV_STAGES-1];

    for (genvar k = 0; k < mvp_pkg::DIV_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign src_vld[k] = i_vld;
            assign src[k]     = i_dat;
        end else begin : g_next
            assign src_vld[k] = r_vld[k-1];
            assign src[k]     = r_dat[k-1];
        end

        assign en[k] = !r_vld[k] || en[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en[k]) begin
                r_vld[k] <= src_vld[k];
            end
            if (en[k]) begin
                r_dat[k] <= div_step(src[k]);
            end
        end

        `MVP_ASSERT(a_rem_below_den, i_clk, i_rst_n, (r_vld[k] && r_dat[k].shape == mvp_pkg::SHAPE_RAMP) |-> (r_dat[k].rem < r_dat[k].den))
    end

    `MVP_ASSERT(a_in_rem_below_den, i_clk, i_rst_n, (i_vld && i_dat.shape == mvp_pkg::SHAPE_RAMP) |-> (i_dat.rem < i_dat.den))
    `MVP_ASSERT(a_quo_in_range, i_clk, i_rst_n, (o_vld && o_dat.shape == mvp_pkg::SHAPE_RAMP) |-> (o_dat.quo <= mvp_pkg::t_quo'(mvp_pkg::ONE)))
endmodule

/* rtl/mvp_smooth.sv */
module mvp_smooth (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mvp_pkg::t_cfg i_cfg,
    input  logic          i_vld,
    input  mvp_pkg::t_div i_dat,
    output logic          o_rdy,
    output logic          o_vld,
    output mvp_pkg::t_val o_mask_value,
    input  logic          i_rdy
);
    logic en_a;
    logic en_b;
    logic en_c;

    mvp_pkg::t_val   t;
    logic            r_vld_a;
    mvp_pkg::t_tt    r_tt;
    mvp_pkg::t_val   r_t;
    mvp_pkg::t_shape r_shape_a;

    mvp_pkg::t_poly  poly;
    logic            r_vld_b;
    mvp_pkg::t_cube  r_cube;
    mvp_pkg::t_shape r_shape_b;

    mvp_pkg::t_cube  rs;
    mvp_pkg::t_val   res;
    mvp_pkg::t_val   n_mask;
    logic            r_vld_c;
    mvp_pkg::t_val   r_mask;

    assign en_c         = !r_vld_c || i_rdy;
    assign en_b         = !r_vld_b || en_c;
    assign en_a         = !r_vld_a || en_b;
    assign o_rdy        = en_a;
    assign o_vld        = r_vld_c;
    assign o_mask_value = r_mask;
    assign t            = i_dat.quo[mvp_pkg::VAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (en_a) begin
            r_vld_a <= i_vld;
        end
        if (en_a) begin
            r_tt      <= mvp_pkg::t_tt'(t) * mvp_pkg::t_tt'(t);
            r_t       <= t;
            r_shape_a <= i_dat.shape;
        end
    end

    assign poly = mvp_pkg::t_poly'(3 * mvp_pkg::ONE) - {r_t, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (en_b) begin
            r_vld_b <= r_vld_a;
        end
        if (en_b) begin
            r_cube    <= mvp_pkg::t_cube'(r_tt) * mvp_pkg::t_cube'(poly);
            r_shape_b <= r_shape_a;
        end
    end

    always_comb begin
        rs = r_cube + mvp_pkg::t_cube'(1 << (2 * mvp_pkg::FRAC_BITS - 1));
        case (r_shape_b)
            mvp_pkg::SHAPE_ZERO: res = '0;
            mvp_pkg::SHAPE_ONE:  res = mvp_pkg::ONE_V;
            mvp_pkg::SHAPE_RAMP: res = rs[2 * mvp_pkg::FRAC_BITS +: mvp_pkg::VAL_W];
            default:             res = '0;
        endcase
        n_mask = i_cfg.invert ? (mvp_pkg::ONE_V - res) : res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
        end else if (en_c) begin
            r_vld_c <= r_vld_b;
        end
        if (en_c) begin
            r_mask <= n_mask;
        end
    end
endmodule

/* rtl/mask_value_postprocess.sv */
// Mask value postprocessor: one signed Q4.12 raw sample in, one Q0.12 mask value (0 to 4096)
// out per transaction. The sample optionally passes a logistic sigmoid (interpolated 257-entry
// table built at elaboration), is scaled by gain (floored at 41) and clamped to [0,1], then shaped
// by a smoothstep of width feather around threshold or by a hard threshold, and optionally
// inverted. The pipeline has thirteen register stages: two for the sigmoid, three for gain and
// shaping, five for the smoothstep divider at three quotient bits per stage, and three for the
// smoothstep polynomial and output register. A new sample is taken every clock while the output
// is not stalled, and internal bubbles are squeezed out under backpressure. Configuration writes
// take effect at once and should only be made while no transaction is in flight.
`include "mask_value_postprocess_assert.svh"

module mask_value_postprocess (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mvp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mvp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    mvp_in_if.sink                              i_in,
    mvp_out_if.source                           o_out
);
    mvp_pkg::t_cfg r_cfg;

    logic          sig_vld;
    logic          sig_rdy;
    mvp_pkg::t_ext sig_v;
    logic          gain_vld;
    logic          gain_rdy;
    mvp_pkg::t_div gain_dat;
    logic          div_vld;
    logic          div_rdy;
    mvp_pkg::t_div div_dat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain       <= mvp_pkg::t_gain'(mvp_pkg::ONE);
            r_cfg.sig_enable <= 1'b0;
            r_cfg.sig_apply  <= 1'b0;
            r_cfg.threshold  <= mvp_pkg::t_level'(mvp_pkg::ONE / 2);
            r_cfg.feather    <= '0;
            r_cfg.invert     <= 1'b0;
        end else if (i_cfg_we) begin
            case (mvp_pkg::t_cfg_idx'(i_cfg_idx))
                mvp_pkg::CFG_GAIN:       r_cfg.gain       <= i_cfg_data[mvp_pkg::GAIN_W-1:0];
                mvp_pkg::CFG_SIG_ENABLE: r_cfg.sig_enable <= i_cfg_data[0];
                mvp_pkg::CFG_SIG_APPLY:  r_cfg.sig_apply  <= i_cfg_data[0];
                mvp_pkg::CFG_THRESHOLD:  r_cfg.threshold  <= i_cfg_data[mvp_pkg::LEVEL_W-1:0];
                mvp_pkg::CFG_FEATHER:    r_cfg.feather    <= i_cfg_data[mvp_pkg::LEVEL_W-1:0];
                mvp_pkg::CFG_INVERT:     r_cfg.invert     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    mvp_sigmoid u_sigmoid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_vld    (i_in.valid),
        .i_sample (i_in.raw_sample),
        .o_rdy    (i_in.ready),
        .o_vld    (sig_vld),
        .o_v      (sig_v),
        .i_rdy    (sig_rdy)
    );

    mvp_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (sig_vld),
        .i_v     (sig_v),
        .o_rdy   (sig_rdy),
        .o_vld   (gain_vld),
        .o_dat   (gain_dat),
        .i_rdy   (gain_rdy)
    );

    mvp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (gain_vld),
        .i_dat   (gain_dat),
        .o_rdy   (gain_rdy),
        .o_vld   (div_vld),
        .o_dat   (div_dat),
        .i_rdy   (div_rdy)
    );

    mvp_smooth u_smooth (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_vld        (div_vld),
        .i_dat        (div_dat),
        .o_rdy        (div_rdy),
        .o_vld        (o_out.valid),
        .o_mask_value (o_out.mask_value),
        .i_rdy        (o_out.ready)
    );

    `MVP_ASSERT(a_out_in_range, i_clk, i_rst_n, o_out.valid |-> (o_out.mask_value <= mvp_pkg::ONE_V))
    `MVP_ASSERT_RST(a_rst_clears_out, i_clk, $past(!i_rst_n) |-> !o_out.valid)
endmodule

/* tb/sv/mask_value_postprocess_tb.sv */
module mask_value_postprocess_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvp_pkg::*;

    typedef longint unsigned t_u64;

    typedef struct {
        t_sample sample;
        t_val    value;
    } t_pending_mask;

    localparam int     LUT_DEPTH     = 256;
    localparam int     FRAC          = 12;
    localparam longint UNITY         = 64'sd1 <<< FRAC;
    localparam longint MIN_GAIN      = (UNITY + 50) / 100;
    localparam t_u64   Q30           = 64'd1 << 30;
    localparam t_u64   INV_E_Q30     = 64'd395007542;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int     QUIET_LIMIT   = 5000;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     STALL_CYCLES  = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mvp_in_if  in_if();
    mvp_out_if out_if();

    mask_value_postprocess u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    t_gain         cfg_gain;
    logic          cfg_sig_enable;
    logic          cfg_sig_apply;
    t_level        cfg_threshold;
    t_level        cfg_feather;
    logic          cfg_invert;
    longint        logistic_lut [0:LUT_DEPTH];
    t_pending_mask pending_masks [$];
    t_pending_mask oldest;
    int            error_count  = 0;
    int            quiet_cycles = 0;
    int            tx_idle_pct  = 0;
    int            rx_idle_pct  = 0;
    int            hold_left    = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_u64 decay_q30(input t_u64 xq);
        t_u64 whole;
        t_u64 frac;
        t_u64 term;
        t_u64 total;
        t_u64 z;
        whole = xq >> 30;
        frac  = xq & (Q30 - 1);
        term  = Q30;
        total = Q30;
        for (int k = 1; k <= 20; k++) begin
            term  = ((term * frac) >> 30) / t_u64'(k);
            total = total + term;
        end
        z = ((64'd1 << 60) + total / 2) / total;
        while (whole > 0 && z != 0) begin
            z     = (z * INV_E_Q30 + Q30 / 2) >> 30;
            whole = whole - 1;
        end
        return z;
    endfunction

    // Entry i is the logistic value at i / 32 in Q0.12.
    function automatic void build_logistic_lut();
        t_u64 xq;
        t_u64 den;
        for (int i = 0; i <= LUT_DEPTH; i++) begin
            xq  = (t_u64'(i) << (45 - FRAC)) / t_u64'(LUT_DEPTH);
            den = Q30 + decay_q30(xq);
            logistic_lut[i] = longint'(((64'd1 << (FRAC + 30)) + den / 2) / den);
        end
    endfunction

    function automatic longint effective_gain();
        return (cfg_gain < MIN_GAIN) ? MIN_GAIN : longint'(cfg_gain);
    endfunction

    function automatic t_val predict_mask(input t_sample raw);
        longint v;
        longint prod;
        longint f;
        longint n;
        longint t;
        longint res;
        t_u64   mag;
        t_u64   pos;
        t_u64   idx;
        t_u64   r;
        t_u64   y;
        v = raw;
        if (cfg_sig_enable && cfg_sig_apply) begin
            mag = t_u64'((v < 0) ? -v : v);
            pos = mag * t_u64'(LUT_DEPTH);
            idx = pos >> 15;
            r   = pos & 64'h7FFF;
            if (idx >= t_u64'(LUT_DEPTH)) begin
                y = t_u64'(logistic_lut[LUT_DEPTH]);
            end else begin
                y = t_u64'(logistic_lut[idx])
                    + ((t_u64'(logistic_lut[idx + 1] - logistic_lut[idx]) * r + 64'h4000) >> 15);
            end
            v = (raw < 0) ? UNITY - longint'(y) : longint'(y);
        end
        prod = v * effective_gain();
        if (prod <= 0) begin
            v = 0;
        end else begin
            v = (prod + (UNITY >>> 1)) >>> FRAC;
            if (v > UNITY) begin
                v = UNITY;
            end
        end
        if (cfg_feather != 0) begin
            f = longint'(cfg_feather);
            n = 2 * v - 2 * longint'(cfg_threshold) + f;
            if (n <= 0) begin
                res = 0;
            end else if (n >= 2 * f) begin
                res = UNITY;
            end else begin
                t   = ((n <<< FRAC) + f) / (2 * f);
                res = (t * t * (3 * UNITY - 2 * t) + (64'sd1 <<< (2 * FRAC - 1))) >>> (2 * FRAC);
            end
        end else begin
            res = (v >= longint'(cfg_threshold)) ? UNITY : 0;
        end
        if (cfg_invert) begin
            res = UNITY - res;
        end
        if (res < 0) begin
            res = 0;
        end
        if (res > UNITY) begin
            res = UNITY;
        end
        return t_val'(res);
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GAIN:       cfg_gain       = data;
            CFG_SIG_ENABLE: cfg_sig_enable = data[0];
            CFG_SIG_APPLY:  cfg_sig_apply  = data[0];
            CFG_THRESHOLD:  cfg_threshold  = data[LEVEL_W-1:0];
            CFG_FEATHER:    cfg_feather    = data[LEVEL_W-1:0];
            CFG_INVERT:     cfg_invert     = data[0];
            default: ;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_level();
        case ($urandom_range(7))
            0:       return CFG_DATA_W'(0);
            1:       return CFG_DATA_W'(4096);
            2:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(0, 4096));
        endcase
    endfunction

    function automatic t_sample next_sample();
        longint target;
        case ($urandom_range(9))
            0, 1:    return t_sample'($urandom);
            2, 3, 4: return t_sample'($urandom_range(0, 4400));
            5, 6, 7: begin
                target = longint'(cfg_threshold) - longint'(cfg_feather) - 64
                         + longint'($urandom_range(0, 2 * int'(cfg_feather) + 128));
                target = target * UNITY / effective_gain();
                if (target > 32767) begin
                    target = 32767;
                end
                if (target < -32768) begin
                    target = -32768;
                end
                return t_sample'(target);
            end
            default: return t_sample'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_sample(input t_sample raw);
        int            gap;
        t_pending_mask entry;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid      = 1'b1;
        in_if.raw_sample = raw;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        entry.sample = raw;
        entry.value  = predict_mask(raw);
        pending_masks.insert(pending_masks.size(), entry);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (pending_masks.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic randomize_settings();
        logic [CFG_DATA_W-1:0] gain_word;
        case ($urandom_range(7))
            0:       gain_word = CFG_DATA_W'($urandom_range(0, 48));
            1:       gain_word = CFG_DATA_W'(16'hFFFF);
            2:       gain_word = CFG_DATA_W'($urandom);
            default: gain_word = CFG_DATA_W'($urandom_range(2048, 12288));
        endcase
        write_reg(CFG_GAIN, gain_word);
        write_reg(CFG_SIG_ENABLE, CFG_DATA_W'($urandom));
        write_reg(CFG_SIG_APPLY, CFG_DATA_W'($urandom));
        write_reg(CFG_THRESHOLD, pick_level());
        write_reg(CFG_FEATHER, ($urandom_range(2) == 0) ? CFG_DATA_W'(0) : pick_level());
        write_reg(CFG_INVERT, CFG_DATA_W'($urandom));
        if ($urandom_range(3) == 0) begin
            write_reg(($urandom_range(1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      CFG_DATA_W'($urandom));
        end
    endtask

    task automatic test_default_settings();
        send_sample(t_sample'(16'h8000));
        send_sample(t_sample'(16'h7FFF));
        send_sample(t_sample'(0));
        send_sample(t_sample'(2047));
        send_sample(t_sample'(2048));
        send_sample(t_sample'(16'hFFFF));
        drain_results();
    endtask

    task automatic test_gain_limits();
        write_reg(CFG_GAIN, CFG_DATA_W'(0));
        send_sample(t_sample'(32767));
        send_sample(t_sample'(100));
        drain_results();
        write_reg(CFG_GAIN, CFG_DATA_W'(16'hFFFF));
        send_sample(t_sample'(1));
        send_sample(t_sample'(128));
        drain_results();
    endtask

    task automatic test_sigmoid_lookup();
        write_reg(CFG_GAIN, CFG_DATA_W'(4096));
        write_reg(CFG_SIG_ENABLE, CFG_DATA_W'(1));
        write_reg(CFG_SIG_APPLY, CFG_DATA_W'(0));
        send_sample(t_sample'(-4096));
        drain_results();
        write_reg(CFG_SIG_APPLY, CFG_DATA_W'(1));
        write_reg(CFG_FEATHER, CFG_DATA_W'(4096));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(2048));
        send_sample(t_sample'(16'h8000));
        send_sample(t_sample'(16'h7FFF));
        send_sample(t_sample'(0));
        send_sample(t_sample'(-4096));
        send_sample(t_sample'(4096));
        send_sample(t_sample'(128));
        drain_results();
    endtask

    task automatic test_soft_edge();
        write_reg(CFG_SIG_ENABLE, CFG_DATA_W'(0));
        write_reg(CFG_FEATHER, CFG_DATA_W'(1001));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(3000));
        send_sample(t_sample'(2500));
        send_sample(t_sample'(3000));
        send_sample(t_sample'(3500));
        send_sample(t_sample'(1000));
        send_sample(t_sample'(4095));
        drain_results();
    endtask

    task automatic test_cut_above_one();
        write_reg(CFG_FEATHER, CFG_DATA_W'(0));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(8191));
        send_sample(t_sample'(32767));
        drain_results();
        write_reg(CFG_INVERT, CFG_DATA_W'(1));
        send_sample(t_sample'(32767));
        drain_results();
        write_reg(CFG_INVERT, CFG_DATA_W'(0));
    endtask

    task automatic test_register_masking();
        write_reg(CFG_SIG_ENABLE, CFG_DATA_W'(16'hFFFE));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(16'hE800));
        write_reg(CFG_FEATHER, CFG_DATA_W'(16'hE000));
        write_reg(CFG_SPARE_LO, CFG_DATA_W'(0));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'(16'hFFFF));
        send_sample(t_sample'(2048));
        send_sample(t_sample'(2047));
        drain_results();
    endtask

    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(posedge i_clk);
        hold_left = STALL_CYCLES;
        repeat (60) send_sample(next_sample());
        drain_results();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int blocks);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (blocks) begin
            randomize_settings();
            repeat ($urandom_range(40, 100)) send_sample(next_sample());
            drain_results();
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left--;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_masks.size() == 0) begin
                error_count++;
                $display("%0t: unexpected transaction, expected none, actual mask_value %0d",
                         $time, out_if.mask_value);
            end else begin
                oldest = pending_masks.pop_front();
                if (out_if.mask_value !== oldest.value) begin
                    error_count++;
                    $display("%0t: raw_sample %0d: expected mask_value %0d, actual %0d",
                             $time, oldest.sample, oldest.value, out_if.mask_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("mask_value_postprocess test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.raw_sample = '0;
        out_if.ready     = 1'b0;
        cfg_gain         = 16'd4096;
        cfg_sig_enable   = 1'b0;
        cfg_sig_apply    = 1'b0;
        cfg_threshold    = 13'd2048;
        cfg_feather      = 13'd0;
        cfg_invert       = 1'b0;
        build_logistic_lut();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        tx_idle_pct = 19;
        rx_idle_pct = 80;
        test_default_settings();
        test_gain_limits();
        test_sigmoid_lookup();
        test_soft_edge();
        test_cut_above_one();
        test_register_masking();
        test_random_traffic(19, 80, 8);
        test_output_stall();
        test_random_traffic(80, 19, 8);
        test_random_traffic(0, 0, 8);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("mask_value_postprocess test passed");
        end else begin
            $display("mask_value_postprocess test failed");
        end
        $finish;
    end

endmodule
